FILE: rtl/huffman_tree_walk_decoder_core_macros.svh
// assertion helpers for the decoder core
`ifndef HUFFMAN_TREE_WALK_DECODER_CORE_MACROS_SVH
`define HUFFMAN_TREE_WALK_DECODER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define HTWD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("htwd check failed");

// next-cycle implication, checked outside reset
`define HTWD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("htwd check failed");

`endif

FILE: rtl/htwd_pkg.sv
package htwd_pkg;

  localparam int IDX_W          = 9;
  localparam int SYM_W          = 8;
  localparam int COUNT_W        = 31;
  localparam int BYTE_W         = 8;
  localparam int BIT_CNT_W      = 4;
  localparam int DEF_TREE_NODES = 512;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_START = 2'd2
  } cmd_t;

  typedef enum logic {
    REG_ROOT  = 1'b0,
    REG_COUNT = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] sym;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } node_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] index;
    node_t            entry;
  } node_wr_t;

endpackage

FILE: rtl/htwd_node_table.sv
module htwd_node_table #(
  parameter int TREE_NODES = htwd_pkg::DEF_TREE_NODES
) (
  input  logic                      clk,
  input  htwd_pkg::node_wr_t        wr,
  input  logic                      rd_en,
  input  logic [htwd_pkg::IDX_W-1:0] rd_index,
  output htwd_pkg::node_t           rd_data
);

  localparam int ADDR_W = (TREE_NODES > 1) ? $clog2(TREE_NODES) : 1;
  localparam logic [htwd_pkg::IDX_W:0] NODES_L = (htwd_pkg::IDX_W + 1)'(TREE_NODES);

  htwd_pkg::node_t mem [TREE_NODES];
  htwd_pkg::node_t mem_q;
  logic            rd_oob;
  logic            wr_in_range;
  logic            rd_in_range;

  assign wr_in_range = {1'b0, wr.index} < NODES_L;
  assign rd_in_range = {1'b0, rd_index} < NODES_L;

  always_ff @(posedge clk) begin
    if (wr.en && wr_in_range) begin
      mem[wr.index[ADDR_W-1:0]] <= wr.entry;
    end
  end

  // entries beyond the table read as an all-zero inner node
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q  <= mem[rd_index[ADDR_W-1:0]];
      rd_oob <= !rd_in_range;
    end
  end

  assign rd_data = rd_oob ? '0 : mem_q;

endmodule

FILE: rtl/huffman_tree_walk_decoder_core.sv
// huffman tree-walk decoder
// channels: a command request is taken on a clock edge with start high and
// busy low. cmd selects a node load (written to the table at once), a data
// byte, or a start of a new file (walk back to the root, symbol count
// cleared). config writes go through cfg_valid/cfg_ready (always ready); the
// user must make them only while busy is low; the block does not enforce it.
// results: each decoded symbol shows on symbol/last/file_done for one cycle
// with strobe high; the receiver cannot stall and must take it then.
// timing: a data byte holds busy while it is walked: one node table read
// per coded bit (the walk is a chain of dependent reads on the single table
// port), one more read per leaf to fetch the root again, and a closing flush
// state. a new root is used from the next start or the next leaf on.
// a symbol is shown in the cycle after the next leaf of the same byte is found,
// and the last symbol of a byte in the cycle after the flush state, as busy
// falls, with last set. a byte that arrives once the count is reached leaves
// busy low. load, start and unused commands never raise busy.
// reset: synchronous and active high; clears the walk, count, config and
// strobe. the node table keeps its content and must be loaded before use.
module huffman_tree_walk_decoder_core #(
  parameter int TREE_NODES = htwd_pkg::DEF_TREE_NODES
) (
  input  logic                          clk,
  input  logic                          rst,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    cmd,
  input  logic [htwd_pkg::IDX_W-1:0]    node_index,
  input  logic                          leaf_flag,
  input  logic [htwd_pkg::SYM_W-1:0]    leaf_symbol,
  input  logic [htwd_pkg::IDX_W-1:0]    left_child,
  input  logic [htwd_pkg::IDX_W-1:0]    right_child,
  input  logic [htwd_pkg::BYTE_W-1:0]   data_byte,
  // config channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [htwd_pkg::COUNT_W-1:0]  cfg_data,
  // result channel
  output logic                          strobe,
  output logic [htwd_pkg::SYM_W-1:0]    symbol,
  output logic                          last,
  output logic                          file_done
);

  // config registers
  logic [htwd_pkg::IDX_W-1:0]   root_index;
  logic [htwd_pkg::COUNT_W-1:0] symbol_count;

  // walk state
  htwd_pkg::state_t             state;
  htwd_pkg::state_t             state_next;
  logic [htwd_pkg::IDX_W-1:0]   current_node;
  logic [htwd_pkg::COUNT_W-1:0] decoded_count;
  logic [htwd_pkg::COUNT_W-1:0] count_inc;
  logic [htwd_pkg::BYTE_W-1:0]  bit_sr;       // coded bits, msb leaves first
  logic [htwd_pkg::BIT_CNT_W-1:0] bits_left;
  logic                         child_rd;     // read data is a freshly taken child

  // symbol held back until we know whether it ends the byte
  logic                         pend_valid;
  logic [htwd_pkg::SYM_W-1:0]   pend_sym;
  logic                         pend_done;

  // table access
  htwd_pkg::node_wr_t           node_wr;
  logic                         rd_en;
  logic [htwd_pkg::IDX_W-1:0]   rd_index;
  htwd_pkg::node_t              rd_data;

  // per-cycle actions
  logic                         accept;
  logic                         reached;
  logic                         begin_byte;
  logic                         start_file;
  logic                         take_leaf;
  logic                         take_branch;
  logic                         flush;
  logic [htwd_pkg::IDX_W-1:0]   child;

  htwd_node_table #(
    .TREE_NODES(TREE_NODES)
  ) u_table (
    .clk     (clk),
    .wr      (node_wr),
    .rd_en   (rd_en),
    .rd_index(rd_index),
    .rd_data (rd_data)
  );

  assign busy      = (state != htwd_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign reached   = (decoded_count >= symbol_count);
  assign count_inc = decoded_count + htwd_pkg::COUNT_W'(1);
  assign child     = bit_sr[htwd_pkg::BYTE_W-1] ? rd_data.right : rd_data.left;

  // load requests go straight to the table
  always_comb begin
    node_wr.en          = accept && (cmd == htwd_pkg::CMD_LOAD);
    node_wr.index       = node_index;
    node_wr.entry.leaf  = leaf_flag;
    node_wr.entry.sym   = leaf_symbol;
    node_wr.entry.left  = left_child;
    node_wr.entry.right = right_child;
  end

  // action decode
  always_comb begin
    begin_byte  = 1'b0;
    start_file  = 1'b0;
    take_leaf   = 1'b0;
    take_branch = 1'b0;
    flush       = 1'b0;
    rd_en       = 1'b0;
    rd_index    = current_node;
    case (state)
      htwd_pkg::ST_IDLE: begin
        if (accept) begin
          case (cmd)
            htwd_pkg::CMD_DATA: begin
              // fetch the node the walk stands on
              if (!reached) begin
                begin_byte = 1'b1;
                rd_en      = 1'b1;
                rd_index   = current_node;
              end
            end
            htwd_pkg::CMD_START: start_file = 1'b1;
            default: ;
          endcase
        end
      end
      htwd_pkg::ST_WALK: begin
        if (child_rd && rd_data.leaf) begin
          // landed on a leaf: emit and go back to the root
          take_leaf = 1'b1;
          rd_en     = 1'b1;
          rd_index  = root_index;
        end else if ((bits_left != '0) && !reached && !rd_data.leaf) begin
          take_branch = 1'b1;
          rd_en       = 1'b1;
          rd_index    = child;
        end
      end
      htwd_pkg::ST_FLUSH: flush = pend_valid;
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      htwd_pkg::ST_IDLE: begin
        if (begin_byte) state_next = htwd_pkg::ST_WALK;
      end
      htwd_pkg::ST_WALK: begin
        if (take_leaf) begin
          state_next = (bits_left == '0) ? htwd_pkg::ST_FLUSH : htwd_pkg::ST_WALK;
        end else if (!take_branch) begin
          // out of bits, count reached, or stuck on a leaf
          state_next = htwd_pkg::ST_FLUSH;
        end
      end
      htwd_pkg::ST_FLUSH: state_next = htwd_pkg::ST_IDLE;
      default: state_next = htwd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= htwd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      root_index   <= '0;
      symbol_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (htwd_pkg::reg_idx_t'(cfg_index))
        htwd_pkg::REG_ROOT:  root_index   <= cfg_data[htwd_pkg::IDX_W-1:0];
        htwd_pkg::REG_COUNT: symbol_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // walk position and symbol count
  always_ff @(posedge clk) begin
    if (rst) begin
      current_node  <= '0;
      decoded_count <= '0;
      child_rd      <= 1'b0;
    end else begin
      if (start_file) begin
        current_node  <= root_index;
        decoded_count <= '0;
      end
      if (begin_byte) begin
        child_rd <= 1'b0;
      end
      if (take_branch) begin
        current_node <= child;
        child_rd     <= 1'b1;
      end
      if (take_leaf) begin
        current_node  <= root_index;
        decoded_count <= count_inc;
        child_rd      <= 1'b0;
      end
    end
  end

  // coded bit shift register, one bit per branch
  always_ff @(posedge clk) begin
    if (begin_byte) begin
      bit_sr    <= data_byte;
      bits_left <= htwd_pkg::BIT_CNT_W'(htwd_pkg::BYTE_W);
    end else if (take_branch) begin
      bit_sr    <= {bit_sr[htwd_pkg::BYTE_W-2:0], 1'b0};
      bits_left <= bits_left - htwd_pkg::BIT_CNT_W'(1);
    end
  end

  // pending symbol
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (take_leaf) begin
      pend_valid <= 1'b1;
    end else if (state == htwd_pkg::ST_FLUSH) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_leaf) begin
      pend_sym  <= rd_data.sym;
      pend_done <= (count_inc == symbol_count);
    end
  end

  // result register: an older pending symbol leaves when a new leaf arrives,
  // the final one of the byte leaves after the closing cycle with last set
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (take_leaf && pend_valid) || flush;
    end
  end

  always_ff @(posedge clk) begin
    if ((take_leaf && pend_valid) || flush) begin
      symbol    <= pend_sym;
      file_done <= pend_done;
      last      <= flush;
    end
  end

  `include "huffman_tree_walk_decoder_core_macros.svh"

  // a byte that still has symbols to decode always starts a walk
  `HTWD_ASSERT_NEXT(a_byte_starts_walk, clk, rst, accept && (cmd == htwd_pkg::CMD_DATA) && !reached, busy)
  // a held symbol is always delivered as the end of its byte
  `HTWD_ASSERT_NEXT(a_flush_delivers, clk, rst, (state == htwd_pkg::ST_FLUSH) && pend_valid, strobe && last)
  // the symbol that completes the file is always delivered as the last of its byte
  `HTWD_ASSERT_NOW(a_done_is_last, clk, rst, strobe && file_done, last)

endmodule
